// ----- rtl/lbmh_pkg.sv -----
// Shared constants, codes and types of the log-binned mass histogram.
package lbmh_pkg;

  localparam int MaxBins    = 64;
  localparam int MassW      = 48;
  localparam int CountW     = 32;
  localparam int NormW      = 48;
  localparam int NormHalfW  = NormW / 2;
  localparam int CmdW       = 2;
  localparam int SlotW      = 7;
  localparam int BinW       = 6;
  localparam int StatusW    = 3;
  localparam int OutW       = 64;
  localparam int ProdW      = CountW + NormW;
  localparam int MulW       = CountW + NormHalfW;
  localparam int RootW      = CountW;
  localparam int RemW       = RootW + 3;
  localparam int RadW       = 2 * RootW;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_BAD_IDX = 3'd4
  } status_e;

  typedef enum logic {
    CFG_BINS = 1'b0,
    CFG_NORM = 1'b1
  } cfg_idx_e;

  // One classified command as it waits between front and back.
  typedef struct packed {
    cmd_e             op;
    logic [SlotW-1:0] slot;
    logic [MassW-1:0] mass;
    logic             bad_slot;
    logic             zero_mass;
  } entry_t;

endpackage

// ----- rtl/lbmh_ifs.sv -----
// Request and response channel interfaces of the histogram.
interface lbmh_req_if;
  import lbmh_pkg::*;
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [SlotW-1:0] slot;
  logic [MassW-1:0] mass_value;
  modport source (output valid, cmd, slot, mass_value, input ready);
  modport sink   (input valid, cmd, slot, mass_value, output ready);
endinterface

interface lbmh_rsp_if;
  import lbmh_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [BinW-1:0]    bin_index;
  logic [CountW-1:0]  bin_count;
  logic [OutW-1:0]    number_density;
  logic [OutW-1:0]    poisson_error;
  logic [CountW-1:0]  underflow_total;
  logic [CountW-1:0]  overflow_total;
  logic [MassW-1:0]   edge_low;
  logic [MassW-1:0]   edge_high;
  modport source (output valid, status, bin_index, bin_count, number_density, poisson_error,
                  underflow_total, overflow_total, edge_low, edge_high, input ready);
  modport sink   (input valid, status, bin_index, bin_count, number_density, poisson_error,
                  underflow_total, overflow_total, edge_low, edge_high, output ready);
endinterface

// ----- rtl/lbmh_fifo.sv -----
// Two-entry queue between the classifying front and the execution engine.
module lbmh_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lbmh_pkg::entry_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output lbmh_pkg::entry_t  head_o
);
  import lbmh_pkg::*;

  entry_t     slots_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// ----- rtl/lbmh_engine.sv -----
// Back end: edge memory, bin counters, linear bin search, sqrt and scaling.
module lbmh_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lbmh_pkg::SlotW-1:0]    active_bins_i,
  input  logic [lbmh_pkg::NormW-1:0]    inv_norm_i,
  input  logic                          q_empty_i,
  input  lbmh_pkg::entry_t              q_head_i,
  output logic                          q_pop_o,
  lbmh_rsp_if.source                    rsp
);
  import lbmh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_LO, S_CHK_HI, S_SCAN, S_BIN, S_ELO, S_EHI, S_SQRT, S_MUL, S_FIN
  } state_e;

  localparam logic [CountW-1:0] CountMax = '1;

  state_e              state_q;
  entry_t              item_q;
  logic [SlotW-1:0]    k_q, hits_q;
  logic [BinW-1:0]     bin_q;
  logic [CountW-1:0]   count_q;
  logic [CountW-1:0]   below_q, above_q;
  logic [MaxBins-1:0]  cvalid_q;
  logic [RadW-1:0]     rad_q;
  logic [RootW-1:0]    root_q;
  logic [RemW-1:0]     rem_q;
  logic [4:0]          iter_q;
  logic [2:0]          mstep_q;
  logic [MulW-1:0]     mul_q;
  logic [ProdW-1:0]    dens_q, err_q;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [BinW-1:0]     out_bin_q;
  logic [CountW-1:0]   out_count_q;
  logic [OutW-1:0]     out_dens_q, out_err_q;
  logic [MassW-1:0]    out_elo_q, out_ehi_q;

  // Memories
  logic [MassW-1:0]    edge_mem [MaxBins+1];
  logic [MassW-1:0]    edge_rd_q;
  logic [SlotW-1:0]    edge_ra;
  logic                edge_we;
  logic [CountW-1:0]   cnt_mem [MaxBins];
  logic [CountW-1:0]   cnt_rd_q;
  logic                cnt_we;
  logic [CountW-1:0]   cnt_old, cnt_new;

  logic                start;
  logic                hit;
  logic [SlotW-1:0]    hits_nx;
  logic [RemW-1:0]     rem_sh, trial;
  logic [CountW-1:0]   mul_a;
  logic [NormHalfW-1:0] mul_b;

  assign start   = (state_q == S_IDLE) && !q_empty_i && (!out_valid_q || rsp.ready);
  assign q_pop_o = start;
  assign edge_we = start && (q_head_i.op == CMD_LOAD) && !q_head_i.bad_slot;

  always_comb begin
    case (state_q)
      S_CHK_LO: edge_ra = active_bins_i;
      S_CHK_HI: edge_ra = SlotW'(1);
      S_SCAN:   edge_ra = (k_q == active_bins_i) ? '0 : k_q + SlotW'(1);
      S_BIN:    edge_ra = {1'b0, bin_q};
      S_ELO:    edge_ra = {1'b0, bin_q} + SlotW'(1);
      default:  edge_ra = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[q_head_i.slot] <= q_head_i.mass;
    edge_rd_q <= edge_mem[edge_ra];
  end

  assign cnt_old = cvalid_q[bin_q] ? cnt_rd_q : '0;
  assign cnt_new = (cnt_old == CountMax) ? cnt_old : cnt_old + CountW'(1);
  assign cnt_we  = (state_q == S_ELO) && (item_q.op == CMD_ADD);

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[bin_q] <= cnt_new;
    cnt_rd_q <= cnt_mem[bin_q];
  end

  assign hit     = (edge_rd_q <= item_q.mass);
  assign hits_nx = hits_q + {{(SlotW-1){1'b0}}, hit};
  assign rem_sh  = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign mul_a   = mstep_q[1] ? root_q : count_q;
  assign mul_b   = mstep_q[0] ? inv_norm_i[NormW-1 -: NormHalfW] : inv_norm_i[NormHalfW-1:0];

  assign rsp.valid           = out_valid_q;
  assign rsp.status          = out_status_q;
  assign rsp.bin_index       = out_bin_q;
  assign rsp.bin_count       = out_count_q;
  assign rsp.number_density  = out_dens_q;
  assign rsp.poisson_error   = out_err_q;
  assign rsp.underflow_total = below_q;
  assign rsp.overflow_total  = above_q;
  assign rsp.edge_low        = out_elo_q;
  assign rsp.edge_high       = out_ehi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      below_q      <= '0;
      above_q      <= '0;
      cvalid_q     <= '0;
      item_q       <= '0;
      k_q          <= '0;
      hits_q       <= '0;
      bin_q        <= '0;
      count_q      <= '0;
      rad_q        <= '0;
      root_q       <= '0;
      rem_q        <= '0;
      iter_q       <= '0;
      mstep_q      <= '0;
      mul_q        <= '0;
      dens_q       <= '0;
      err_q        <= '0;
      out_status_q <= ST_OK;
      out_bin_q    <= '0;
      out_count_q  <= '0;
      out_dens_q   <= '0;
      out_err_q    <= '0;
      out_elo_q    <= '0;
      out_ehi_q    <= '0;
    end else begin
      if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            item_q       <= q_head_i;
            out_status_q <= ST_OK;
            out_bin_q    <= '0;
            out_count_q  <= '0;
            out_dens_q   <= '0;
            out_err_q    <= '0;
            out_elo_q    <= '0;
            out_ehi_q    <= '0;
            unique case (q_head_i.op)
              CMD_LOAD: begin
                out_valid_q <= 1'b1;
                if (q_head_i.bad_slot) out_status_q <= ST_BAD_IDX;
                else                   out_elo_q    <= q_head_i.mass;
              end
              CMD_CLEAR: begin
                out_valid_q <= 1'b1;
                cvalid_q    <= '0;
                below_q     <= '0;
                above_q     <= '0;
              end
              CMD_READ: begin
                if (q_head_i.bad_slot) begin
                  out_valid_q  <= 1'b1;
                  out_status_q <= ST_BAD_IDX;
                end else begin
                  bin_q   <= q_head_i.slot[BinW-1:0];
                  state_q <= S_BIN;
                end
              end
              default: begin
                if (q_head_i.zero_mass) begin
                  out_valid_q  <= 1'b1;
                  out_status_q <= ST_ZERO;
                end else begin
                  state_q <= S_CHK_LO;
                end
              end
            endcase
          end
        end
        S_CHK_LO: begin
          if (item_q.mass < edge_rd_q) begin
            if (below_q != CountMax) below_q <= below_q + CountW'(1);
            out_status_q <= ST_UNDER;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            state_q <= S_CHK_HI;
          end
        end
        S_CHK_HI: begin
          if (item_q.mass > edge_rd_q) begin
            if (above_q != CountMax) above_q <= above_q + CountW'(1);
            out_status_q <= ST_OVER;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            k_q     <= SlotW'(1);
            hits_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // count edges 1..n at or below the mass, capped to the last bin
          hits_q <= hits_nx;
          k_q    <= k_q + SlotW'(1);
          if (k_q == active_bins_i) begin
            bin_q   <= (hits_nx >= active_bins_i) ? BinW'(active_bins_i - SlotW'(1))
                                                  : hits_nx[BinW-1:0];
            state_q <= S_BIN;
          end
        end
        S_BIN: state_q <= S_ELO;
        S_ELO: begin
          out_elo_q <= edge_rd_q;
          if (item_q.op == CMD_ADD) begin
            count_q         <= cnt_new;
            cvalid_q[bin_q] <= 1'b1;
          end else begin
            count_q <= cnt_old;
          end
          state_q <= S_EHI;
        end
        S_EHI: begin
          out_ehi_q <= edge_rd_q;
          rad_q     <= {count_q, {RootW{1'b0}}};
          root_q    <= '0;
          rem_q     <= '0;
          iter_q    <= '0;
          state_q   <= S_SQRT;
        end
        S_SQRT: begin
          rad_q <= rad_q << 2;
          if (rem_sh >= trial) begin
            rem_q  <= rem_sh - trial;
            root_q <= {root_q[RootW-2:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[RootW-2:0], 1'b0};
          end
          iter_q <= iter_q + 5'd1;
          if (iter_q == 5'd31) begin
            mstep_q <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // one 32x24 product per cycle, summed in the next cycle
          mul_q   <= mul_a * mul_b;
          mstep_q <= mstep_q + 3'd1;
          case (mstep_q)
            3'd1: dens_q <= ProdW'(mul_q);
            3'd2: dens_q <= dens_q + (ProdW'(mul_q) << NormHalfW);
            3'd3: err_q  <= ProdW'(mul_q);
            3'd4: begin
              err_q   <= err_q + (ProdW'(mul_q) << NormHalfW);
              state_q <= S_FIN;
            end
            default: ;
          endcase
        end
        S_FIN: begin
          out_status_q <= ST_OK;
          out_bin_q    <= bin_q;
          out_count_q  <= count_q;
          out_dens_q   <= (dens_q[ProdW-1:OutW] != '0) ? '1 : dens_q[OutW-1:0];
          out_err_q    <= err_q[ProdW-1:16];
          out_valid_q  <= 1'b1;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/log_binned_mass_histogram_top.sv -----
// Top level of the log-binned mass histogram: config, front classifier, queue, engine.
// Usage:
//   req_i carries commands (load edge, add sample, read bin, clear counts); a transfer
//   happens when valid and ready are both high. rsp_o returns exactly one result per
//   command, in order, with the same valid/ready transfer rule.
//   cfg_we_i/cfg_idx_i/cfg_data_i write bins_in_use (index 0) or inv_norm (index 1);
//   write only while the block is idle.
// Timing:
//   load, clear, zero-mass add and bad-index read: result the cycle after leaving the queue.
//   Underflow/overflow adds, in-range adds and bin reads take longer. The linear edge
//   scan (one edge per cycle from the edge memory), the 32-step square root and four
//   32x24 partial products set the time of the in-range add and the bin read.
//   The engine works one command at a time; a two-entry queue keeps accepting requests.
// Reset:
//   counts, totals and config return to defaults (64 bins, inv_norm = 1.0) at once;
//   edge memory is undefined until loaded.
// Stall:
//   when rsp_o.ready is low the result holds; the engine waits, the queue fills and
//   then req_i.ready drops.
module log_binned_mass_histogram_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [lbmh_pkg::NormW-1:0]   cfg_data_i,
  lbmh_req_if.sink                     req_i,
  lbmh_rsp_if.source                   rsp_o
);
  import lbmh_pkg::*;

  logic [SlotW-1:0] bins_q;
  logic [NormW-1:0] inv_norm_q;
  logic [SlotW-1:0] active_bins;
  entry_t           entry, head;
  logic             full, empty, pop;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q     <= SlotW'(MaxBins);
      inv_norm_q <= NormW'(64'h1_0000_0000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BINS: bins_q     <= cfg_data_i[SlotW-1:0];
        default:  inv_norm_q <= cfg_data_i;
      endcase
    end
  end

  // clamp active bins into 1..MaxBins
  assign active_bins = (bins_q == '0)              ? SlotW'(1) :
                       (bins_q > SlotW'(MaxBins)) ? SlotW'(MaxBins) : bins_q;

  // front: classify each request as it is accepted
  always_comb begin
    entry.op        = cmd_e'(req_i.cmd);
    entry.slot      = req_i.slot;
    entry.mass      = req_i.mass_value;
    entry.zero_mass = (req_i.mass_value == '0);
    case (entry.op)
      CMD_LOAD: entry.bad_slot = (req_i.slot > SlotW'(MaxBins));
      CMD_READ: entry.bad_slot = (req_i.slot >= active_bins);
      default:  entry.bad_slot = 1'b0;
    endcase
  end

  assign req_i.ready = !full;

  lbmh_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (req_i.valid && !full),
    .push_data_i (entry),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  lbmh_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .active_bins_i (active_bins),
    .inv_norm_i    (inv_norm_q),
    .q_empty_i     (empty),
    .q_head_i      (head),
    .q_pop_o       (pop),
    .rsp           (rsp_o)
  );
endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the log-binned mass histogram top level.
`timescale 1ns / 1ps

module tb;
  import lbmh_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainWait  = 200;   // covers the longest in-range add after the last result
  localparam int HoldCycles = 400;   // long receiver hold-off for back-pressure

  typedef struct {
    cmd_e             cmd;
    logic [SlotW-1:0] slot;
    logic [MassW-1:0] mass;
  } hist_cmd_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [BinW-1:0]    bin_index;
    logic [CountW-1:0]  bin_count;
    logic [OutW-1:0]    number_density;
    logic [OutW-1:0]    poisson_error;
    logic [CountW-1:0]  underflow_total;
    logic [CountW-1:0]  overflow_total;
    logic [MassW-1:0]   edge_low;
    logic [MassW-1:0]   edge_high;
  } hist_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [NormW-1:0] cfg_data_i;

  lbmh_req_if req ();
  lbmh_rsp_if rsp ();

  log_binned_mass_histogram_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  // Mirror of the histogram state
  logic [MassW-1:0]  edge_mem [MaxBins+1];
  logic [CountW-1:0] bin_cnt  [MaxBins];
  logic [CountW-1:0] under_cnt;
  logic [CountW-1:0] over_cnt;
  logic [SlotW-1:0]  bins_reg;
  logic [NormW-1:0]  norm_reg;

  // Edge table as the stimulus generator expects it (tracks queued loads)
  logic [MassW-1:0]  planned_edges [MaxBins+1];
  int                planned_bins;

  hist_cmd_t    pending_cmds [$];
  hist_result_t expected_results [$];

  int  errors;
  int  cycle_count;
  bit  calm;        // no idling on either side
  bit  hold_go;     // request for a long receiver hold-off
  int  hold_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int eff_bins(logic [SlotW-1:0] b);
    if (b == 0) return 1;
    if (b > MaxBins) return MaxBins;
    return int'(b);
  endfunction

  function automatic logic [CountW-1:0] sat_bump(logic [CountW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // floor(sqrt(v)) bit by bit; the root of a 64-bit value fits 32 bits
  function automatic logic [31:0] isqrt64(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root[31:0];
  endfunction

  // Fill in count, density and Poisson error for one bin
  function automatic void fill_bin(int bin, ref hist_result_t r);
    logic [95:0] dens;
    logic [95:0] perr;
    logic [31:0] root;
    r.bin_index = bin[BinW-1:0];
    r.bin_count = bin_cnt[bin];
    dens = {64'd0, bin_cnt[bin]} * {48'd0, norm_reg};
    r.number_density = (dens[95:64] != 0) ? '1 : dens[63:0];
    root = isqrt64({bin_cnt[bin], 32'd0});
    perr = {64'd0, root} * {48'd0, norm_reg};
    r.poisson_error = (perr[95:80] != 0) ? '1 : perr[79:16];
    r.edge_low  = edge_mem[bin];
    r.edge_high = edge_mem[bin+1];
  endfunction

  // Apply one accepted command to the mirror and return the result it must produce
  function automatic hist_result_t predict_histogram(hist_cmd_t c);
    hist_result_t r;
    int n;
    int bin;
    n = eff_bins(bins_reg);
    r = '{default: '0};
    r.status = ST_OK;
    case (c.cmd)
      CMD_LOAD: begin
        if (c.slot > MaxBins) begin
          r.status = ST_BAD_IDX;
        end else begin
          edge_mem[c.slot] = c.mass;
          r.edge_low = c.mass;
        end
      end
      CMD_ADD: begin
        if (c.mass == 0) begin
          r.status = ST_ZERO;
        end else if (c.mass < edge_mem[0]) begin
          under_cnt = sat_bump(under_cnt);
          r.status = ST_UNDER;
        end else if (c.mass > edge_mem[n]) begin
          over_cnt = sat_bump(over_cnt);
          r.status = ST_OVER;
        end else begin
          // count of edges 1..n at or below the mass; exactly the top edge lands in the last bin
          bin = 0;
          for (int k = 1; k <= n; k++)
            if (edge_mem[k] <= c.mass) bin++;
          if (bin > n - 1) bin = n - 1;
          bin_cnt[bin] = sat_bump(bin_cnt[bin]);
          fill_bin(bin, r);
        end
      end
      CMD_READ: begin
        if (c.slot >= n) r.status = ST_BAD_IDX;
        else fill_bin(int'(c.slot), r);
      end
      default: begin
        foreach (bin_cnt[i]) bin_cnt[i] = '0;
        under_cnt = '0;
        over_cnt  = '0;
      end
    endcase
    r.underflow_total = under_cnt;
    r.overflow_total  = over_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Driver: holds an offered command until it transfers, idles at random between commands
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready)
        expected_results.push_back(predict_histogram(pending_cmds.pop_front()));
      if (!(req.valid && !req.ready)) begin
        if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 34)) begin
          req.valid      <= 1'b1;
          req.cmd        <= pending_cmds[0].cmd;
          req.slot       <= pending_cmds[0].slot;
          req.mass_value <= pending_cmds[0].mass;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result transfer against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    hist_result_t e;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, rsp.status);
          check_field("bin_index", e.bin_index, rsp.bin_index);
          check_field("bin_count", e.bin_count, rsp.bin_count);
          check_field("number_density", e.number_density, rsp.number_density);
          check_field("poisson_error", e.poisson_error, rsp.poisson_error);
          check_field("underflow_total", e.underflow_total, rsp.underflow_total);
          check_field("overflow_total", e.overflow_total, rsp.overflow_total);
          check_field("edge_low", e.edge_low, rsp.edge_low);
          check_field("edge_high", e.edge_high, rsp.edge_high);
        end
      end
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= calm || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_cmd(cmd_e cmd, int slot, logic [MassW-1:0] mass);
    hist_cmd_t c;
    c.cmd  = cmd;
    c.slot = slot[SlotW-1:0];
    c.mass = mass;
    if (cmd == CMD_LOAD && slot <= MaxBins) planned_edges[slot] = mass;
    pending_cmds.push_back(c);
  endtask

  // Config writes only happen with the block idle
  task automatic write_cfg(cfg_idx_e idx, logic [NormW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BINS) begin
      bins_reg     = data[SlotW-1:0];
      planned_bins = eff_bins(data[SlotW-1:0]);
    end else begin
      norm_reg = data;
    end
  endtask

  // Sender pause: nothing left to offer and every expected result back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() > 0 || req.valid || expected_results.size() > 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic queue_random(int count);
    int sel;
    int k;
    logic [MassW-1:0] m;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 68) begin
        // sample near an edge: on it, just off it, or inside the bin above
        k = $urandom_range(0, planned_bins);
        m = planned_edges[k];
        case ($urandom_range(0, 3))
          0: ;
          1: m = m - 1'b1;
          2: m = m + 1'b1;
          default: m = m + $urandom_range(0, 4000);
        endcase
        queue_cmd(CMD_ADD, 0, m);
      end else if (sel < 76) begin
        m = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) m = '0;
        queue_cmd(CMD_ADD, $urandom_range(0, 127), m);
      end else if (sel < 93) begin
        if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 127);
        else k = $urandom_range(0, planned_bins);
        queue_cmd(CMD_READ, k, {$urandom, $urandom});
      end else if (sel < 97) begin
        k = $urandom_range(0, 127);
        if (k <= MaxBins && $urandom_range(0, 1)) m = planned_edges[k] + $urandom_range(0, 3);
        else m = {$urandom, $urandom};
        queue_cmd(CMD_LOAD, k, m);
      end else begin
        queue_cmd(CMD_CLEAR, $urandom_range(0, 127), {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    errors       = 0;
    cycle_count  = 0;
    calm         = 1'b0;
    hold_go      = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_BINS;
    cfg_data_i   = '0;
    req.valid    = 1'b0;
    req.cmd      = CMD_LOAD;
    req.slot     = '0;
    req.mass_value = '0;
    rsp.ready    = 1'b0;
    bins_reg     = 7'd64;
    norm_reg     = 48'h1_0000_0000;
    planned_bins = MaxBins;
    under_cnt    = '0;
    over_cnt     = '0;
    foreach (bin_cnt[i]) bin_cnt[i] = '0;
    foreach (edge_mem[i]) edge_mem[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults written explicitly: 64 bins, unit normalization
    write_cfg(CFG_BINS, 48'd64);
    write_cfg(CFG_NORM, 48'h1_0000_0000);

    // Log-spaced ascending edges over the whole table before anything reads them
    for (int k = 0; k <= MaxBins; k++)
      queue_cmd(CMD_LOAD, k, (48'd1000 + 48'd500 * (k % 2)) << (k / 2));

    // Directed corners
    queue_cmd(CMD_LOAD, 65, 48'h1234);              // edge index just past the table
    queue_cmd(CMD_LOAD, 127, '1);                   // largest slot, largest mass
    queue_cmd(CMD_ADD, 0, '0);                      // zero mass
    queue_cmd(CMD_ADD, 0, 48'd1);                   // below the lowest edge
    queue_cmd(CMD_ADD, 0, planned_edges[0]);        // exactly the lowest edge
    queue_cmd(CMD_ADD, 0, planned_edges[5]);        // exactly an inner edge
    queue_cmd(CMD_ADD, 0, planned_edges[MaxBins]);  // exactly the top edge -> last bin
    queue_cmd(CMD_ADD, 0, planned_edges[MaxBins] + 1'b1);
    queue_cmd(CMD_ADD, 127, '1);                    // overflow, every slot bit set
    queue_cmd(CMD_READ, 0, '0);
    queue_cmd(CMD_READ, 5, '0);
    queue_cmd(CMD_READ, 63, '0);
    queue_cmd(CMD_READ, 64, '0);                    // read past the active bins
    queue_cmd(CMD_READ, 127, '1);
    queue_cmd(CMD_CLEAR, 0, '0);
    queue_cmd(CMD_READ, 63, '0);

    // Long receiver hold-off while the sender keeps offering: fills the queue
    hold_go = 1'b1;
    queue_random(200);
    wait_drained();

    // One bin, largest normalization, no idling on either side
    write_cfg(CFG_BINS, 48'd1);
    write_cfg(CFG_NORM, '1);
    calm = 1'b1;
    queue_random(120);
    wait_drained();
    calm = 1'b0;

    // Bin count above the table size acts as 64; zero normalization
    write_cfg(CFG_BINS, 48'd127);
    write_cfg(CFG_NORM, '0);
    queue_random(120);
    wait_drained();

    // Zero bins acts as one; smallest nonzero normalization
    write_cfg(CFG_BINS, 48'd0);
    write_cfg(CFG_NORM, 48'd1);
    queue_random(100);
    wait_drained();

    // Random mid settings, upper data bits random too
    write_cfg(CFG_BINS, {$urandom, $urandom} & ~48'h7F | 48'($urandom_range(2, 63)));
    write_cfg(CFG_NORM, {$urandom, $urandom});
    queue_random(260);
    wait_drained();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
